// ----- sv/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types, codes and constants of the six-axis pose slew limiter.
// ----------------------------------------------------------------------------
package psl_pkg;

   localparam int NUM_AXES     = 6;
   localparam int NUM_POS_AXES = 3;
   localparam int COORD_W      = 16;
   localparam int STEP_W       = 15;
   localparam int COUNT_W      = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [STEP_W-1:0]  POSITION_STEP_RESET = STEP_W'(64);
   localparam logic [STEP_W-1:0]  ANGLE_STEP_RESET    = STEP_W'(82);
   localparam logic [COUNT_W-1:0] MAX_STEPS_RESET     = COUNT_W'(1000);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [2:0] {
      ACT_SET_CURRENT = 3'd0,
      ACT_SET_TARGET  = 3'd1,
      ACT_TICK        = 3'd2,
      ACT_STOP        = 3'd3,
      ACT_JUMP        = 3'd4,
      ACT_CLEAR       = 3'd5
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_STEP = 2'd0,
      CSR_ANGLE_STEP    = 2'd1,
      CSR_MAX_STEPS     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      POSE_KEEP,
      POSE_INPUT,
      POSE_LANE,
      POSE_TARGET,
      POSE_ZERO
   } pose_sel_type;

   typedef enum logic [1:0] {
      TGT_KEEP,
      TGT_INPUT,
      TGT_ZERO
   } tgt_sel_type;

   typedef struct packed {
      logic [2:0] action;
      coord_type  in_x;
      coord_type  in_y;
      coord_type  in_z;
      coord_type  in_roll;
      coord_type  in_pitch;
      coord_type  in_yaw;
   } req_type;

   typedef struct packed {
      coord_type          out_x;
      coord_type          out_y;
      coord_type          out_z;
      coord_type          out_roll;
      coord_type          out_pitch;
      coord_type          out_yaw;
      logic               moving;
      logic [COUNT_W-1:0] step_count;
      logic               keep_going;
   } rsp_type;

   typedef struct packed {
      coord_type next_pos;
      logic      differs;
      logic      in_reach;
      logic      input_differs;
   } lane_res_type;

   typedef struct packed {
      pose_sel_type       pose_sel;
      tgt_sel_type        tgt_sel;
      logic               moving;
      logic [COUNT_W-1:0] count;
      logic               keep_going;
   } ctrl_type;

endpackage

// ----- sv/six_axis_pose_slew_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// six_axis_pose_slew_limiter_unit
// Keeps a current and a target six-axis pose; on each tick action while
// moving it steps the current pose toward the target, or snaps it there.
// ----------------------------------------------------------------------------
// Every accepted beat returns exactly one result beat. A beat is taken in any
// cycle in which the skid stage is free, so one beat per clock is sustained;
// the result enters the result register, or the skid stage while earlier
// results still wait on the output stall. Six axis lanes evaluate the
// clamped move in parallel and a merging stage settles the new pose, the
// moving flag and the tick counter within the accepting cycle. Configuration
// writes take effect at once and should be made while no beat is in flight.
module six_axis_pose_slew_limiter_unit
   import psl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [STEP_W-1:0]   position_step_ff;
   logic [STEP_W-1:0]   angle_step_ff;
   logic [COUNT_W-1:0]  max_steps_ff;
   coord_type           cur_ff [NUM_AXES];
   coord_type           cur_in [NUM_AXES];
   coord_type           tgt_ff [NUM_AXES];
   coord_type           tgt_in [NUM_AXES];
   coord_type           in_pose [NUM_AXES];
   logic                moving_ff;
   logic [COUNT_W-1:0]  count_ff;
   lane_res_type        lane_res [NUM_AXES];
   logic [NUM_AXES-1:0] differs;
   logic [NUM_AXES-1:0] in_reach;
   logic [NUM_AXES-1:0] input_differs;
   ctrl_type            ctrl;
   logic                accept;
   rsp_type             result;

   assign accept = req_valid && !req_stall;

   assign in_pose[0] = req_data.in_x;
   assign in_pose[1] = req_data.in_y;
   assign in_pose[2] = req_data.in_z;
   assign in_pose[3] = req_data.in_roll;
   assign in_pose[4] = req_data.in_pitch;
   assign in_pose[5] = req_data.in_yaw;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      psl_lane u_lane (
         .cur_pos (cur_ff[i]),
         .tgt_pos (tgt_ff[i]),
         .in_pos  (in_pose[i]),
         .step    ((i < NUM_POS_AXES) ? position_step_ff : angle_step_ff),
         .res     (lane_res[i])
      );
      assign differs[i]       = lane_res[i].differs;
      assign in_reach[i]      = lane_res[i].in_reach;
      assign input_differs[i] = lane_res[i].input_differs;
   end

   psl_merge u_merge (
      .action        (req_data.action),
      .moving_ff     (moving_ff),
      .count_ff      (count_ff),
      .max_steps_ff  (max_steps_ff),
      .differs       (differs),
      .in_reach      (in_reach),
      .input_differs (input_differs),
      .ctrl          (ctrl)
   );

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         case (ctrl.pose_sel)
            POSE_INPUT:  cur_in[i] = in_pose[i];
            POSE_LANE:   cur_in[i] = lane_res[i].next_pos;
            POSE_TARGET: cur_in[i] = tgt_ff[i];
            POSE_ZERO:   cur_in[i] = '0;
            default:     cur_in[i] = cur_ff[i];
         endcase
         case (ctrl.tgt_sel)
            TGT_INPUT: tgt_in[i] = in_pose[i];
            TGT_ZERO:  tgt_in[i] = '0;
            default:   tgt_in[i] = tgt_ff[i];
         endcase
      end
   end

   always_comb begin
      result.out_x      = cur_in[0];
      result.out_y      = cur_in[1];
      result.out_z      = cur_in[2];
      result.out_roll   = cur_in[3];
      result.out_pitch  = cur_in[4];
      result.out_yaw    = cur_in[5];
      result.moving     = ctrl.moving;
      result.step_count = ctrl.count;
      result.keep_going = ctrl.keep_going;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_step_ff <= POSITION_STEP_RESET;
         angle_step_ff    <= ANGLE_STEP_RESET;
         max_steps_ff     <= MAX_STEPS_RESET;
         moving_ff        <= 1'b0;
         count_ff         <= '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            cur_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_POSITION_STEP: position_step_ff <= csr_wdata[STEP_W-1:0];
               CSR_ANGLE_STEP:    angle_step_ff    <= csr_wdata[STEP_W-1:0];
               CSR_MAX_STEPS:     max_steps_ff     <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            moving_ff <= ctrl.moving;
            count_ff  <= ctrl.count;
            for (int i = 0; i < NUM_AXES; i++) begin
               cur_ff[i] <= cur_in[i];
               tgt_ff[i] <= tgt_in[i];
            end
         end
      end
   end

   psl_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// ----- sv/psl_lane.sv -----
// ----------------------------------------------------------------------------
// psl_lane
// One axis: clamped move toward the target and the per-axis status flags.
// ----------------------------------------------------------------------------
module psl_lane
   import psl_pkg::*;
(
   input  coord_type         cur_pos,
   input  coord_type         tgt_pos,
   input  coord_type         in_pos,
   input  logic [STEP_W-1:0] step,
   output lane_res_type      res
);

   logic signed [COORD_W:0] diff;
   logic        [COORD_W:0] abs_diff;
   logic        [COORD_W:0] lim;
   logic signed [COORD_W:0] moved_pos;

   assign diff     = {tgt_pos[COORD_W-1], tgt_pos} - {cur_pos[COORD_W-1], cur_pos};
   assign abs_diff = diff[COORD_W] ? (COORD_W+1)'(0) - diff : diff;
   assign lim      = {{(COORD_W+1-STEP_W){1'b0}}, step};
   assign moved_pos = diff[COORD_W] ? {cur_pos[COORD_W-1], cur_pos} - lim
                                    : {cur_pos[COORD_W-1], cur_pos} + lim;

   always_comb begin
      res.differs       = (diff != '0);
      res.input_differs = (in_pos != cur_pos);
      // The remaining distance after a move is below one step exactly when the
      // distance before it is below two steps.
      res.in_reach      = ({1'b0, abs_diff} < {lim, 1'b0});
      if (!res.differs) begin
         res.next_pos = cur_pos;
      end else if (abs_diff < lim) begin
         res.next_pos = tgt_pos;
      end else begin
         res.next_pos = moved_pos[COORD_W-1:0];
      end
   end

endmodule

// ----- sv/psl_merge.sv -----
// ----------------------------------------------------------------------------
// psl_merge
// Combines the lane flags with the action and the motion state into the
// update decision for one beat.
// ----------------------------------------------------------------------------
module psl_merge
   import psl_pkg::*;
(
   input  logic [2:0]          action,
   input  logic                moving_ff,
   input  logic [COUNT_W-1:0]  count_ff,
   input  logic [COUNT_W-1:0]  max_steps_ff,
   input  logic [NUM_AXES-1:0] differs,
   input  logic [NUM_AXES-1:0] in_reach,
   input  logic [NUM_AXES-1:0] input_differs,
   output ctrl_type            ctrl
);

   always_comb begin
      ctrl.pose_sel   = POSE_KEEP;
      ctrl.tgt_sel    = TGT_KEEP;
      ctrl.moving     = moving_ff;
      ctrl.count      = count_ff;
      ctrl.keep_going = 1'b0;
      case (action)
         ACT_SET_CURRENT: begin
            ctrl.pose_sel = POSE_INPUT;
         end
         ACT_SET_TARGET: begin
            ctrl.tgt_sel = TGT_INPUT;
            ctrl.moving  = |input_differs;
            ctrl.count   = '0;
         end
         ACT_TICK: begin
            if (moving_ff) begin
               if (count_ff >= max_steps_ff) begin
                  ctrl.pose_sel = POSE_TARGET;
                  ctrl.moving   = 1'b0;
               end else begin
                  ctrl.count = count_ff + COUNT_W'(1);
                  if (!(|differs) || (&in_reach)) begin
                     ctrl.pose_sel = POSE_TARGET;
                     ctrl.moving   = 1'b0;
                  end else begin
                     ctrl.pose_sel   = POSE_LANE;
                     ctrl.keep_going = 1'b1;
                  end
               end
            end
         end
         ACT_STOP: begin
            ctrl.moving = 1'b0;
         end
         ACT_JUMP: begin
            ctrl.pose_sel = POSE_TARGET;
            ctrl.moving   = 1'b0;
         end
         ACT_CLEAR: begin
            ctrl.pose_sel = POSE_ZERO;
            ctrl.tgt_sel  = TGT_ZERO;
            ctrl.moving   = 1'b0;
            ctrl.count    = '0;
         end
         default: begin
            ctrl.pose_sel = POSE_KEEP;
         end
      endcase
   end

endmodule

// ----- sv/psl_skid.sv -----
// ----------------------------------------------------------------------------
// psl_skid
// Result register with a skid stage, so the input side never waits on the
// output stall in the same cycle.
// ----------------------------------------------------------------------------
module psl_skid
   import psl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_stall,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type main_ff;
   rsp_type main_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    out_fire;
   logic    in_fire;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign out_fire  = main_valid_ff && !out_stall;
   assign in_fire   = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || out_fire) begin
         main_valid_in = in_fire;
         main_in       = in_data;
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- sv/psl_checker.sv -----
// ----------------------------------------------------------------------------
// psl_checker
// Port-level checks of the pose slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module psl_checker
   import psl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // No result beat is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result beat stays offered and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

   // A tick that asks for more ticks leaves the block moving.
   a_keep_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.keep_going) |-> rsp_data.moving)
      else $error("keep_going without moving");

   // A tick that asks for more ticks has advanced the counter.
   a_keep_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.keep_going) |-> (rsp_data.step_count != '0))
      else $error("keep_going with zero step count");

   // The input side is only held off while a result beat is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind six_axis_pose_slew_limiter_unit psl_checker u_psl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- bench/six_axis_pose_slew_limiter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_axis_pose_slew_limiter_unit_tb
// Self-checking bench for the six-axis pose slew limiter. A driver pulls
// action beats from a pending queue, and a built-in pose model predicts each
// result at acceptance. A monitor compares every result beat field by field
// with the oldest prediction. The run walks through several step and limit
// settings and through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module six_axis_pose_slew_limiter_unit_tb;
   import psl_pkg::*;

   typedef logic [NUM_AXES-1:0][COORD_W-1:0] pose_vec;

   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;
   localparam int PHASES = 6;
   localparam int RANDOM_PER_PHASE = 165;
   localparam int QUIET_LIMIT = 2000;

   localparam logic [PHASES-1:0][CSR_DATA_W-1:0] POS_PLAN =
      {16'd64, 16'd200, 16'd300, 16'd0, 16'd32767, 16'd1};
   localparam logic [PHASES-1:0][CSR_DATA_W-1:0] ANG_PLAN =
      {16'd82, 16'd250, 16'd0, 16'd100, 16'd1, 16'd32767};
   localparam logic [PHASES-1:0][CSR_DATA_W-1:0] LIMIT_PLAN =
      {16'd1000, 16'd20, 16'd0, 16'd5, 16'd65535, 16'd2};
   localparam logic [PHASES-1:0][7:0] SEND_PLAN =
      {8'd35, 8'd67, 8'd0, 8'd35, 8'd0, 8'd67};
   localparam logic [PHASES-1:0][7:0] STALL_PLAN =
      {8'd35, 8'd0, 8'd0, 8'd35, 8'd67, 8'd0};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pose_vec            pose_now = '0;
   pose_vec            pose_goal = '0;
   logic               moving_now = 1'b0;
   logic [COUNT_W-1:0] ticks_taken = '0;
   logic [STEP_W-1:0]  pos_step = POSITION_STEP_RESET;
   logic [STEP_W-1:0]  ang_step = ANGLE_STEP_RESET;
   logic [COUNT_W-1:0] tick_limit = MAX_STEPS_RESET;

   req_type actions_pending[$];
   rsp_type pose_results_due[$];
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      fail_count = 0;
   int      quiet_cycles = 0;

   six_axis_pose_slew_limiter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int step_of(int axis);
      return (axis < NUM_POS_AXES) ? int'(pos_step) : int'(ang_step);
   endfunction

   function automatic int gap_of(pose_vec from_pose, pose_vec to_pose, int axis);
      return int'(coord_type'(to_pose[axis])) - int'(coord_type'(from_pose[axis]));
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic rsp_type slew_pose(req_type beat);
      pose_vec given;
      rsp_type res;
      logic    advance;
      logic    moved;
      logic    settled;
      int      diff;
      int      lim;
      int      i;
      given = {beat.in_yaw, beat.in_pitch, beat.in_roll, beat.in_z, beat.in_y, beat.in_x};
      advance = 1'b0;
      case (beat.action)
         ACT_SET_CURRENT: pose_now = given;
         ACT_SET_TARGET: begin
            pose_goal = given;
            moving_now = (pose_now != pose_goal);
            ticks_taken = '0;
         end
         ACT_TICK: begin
            if (moving_now && ticks_taken >= tick_limit) begin
               pose_now = pose_goal;
               moving_now = 1'b0;
            end else if (moving_now) begin
               moved = 1'b0;
               for (i = 0; i < NUM_AXES; i++) begin
                  diff = gap_of(pose_now, pose_goal, i);
                  lim = step_of(i);
                  if (diff != 0) begin
                     moved = 1'b1;
                     if (magnitude(diff) < lim)
                        pose_now[i] = pose_goal[i];
                     else
                        pose_now[i] = COORD_W'(int'(coord_type'(pose_now[i]))
                                               + ((diff < 0) ? -lim : lim));
                  end
               end
               ticks_taken = ticks_taken + 1'b1;
               settled = !moved;
               if (moved) begin
                  settled = 1'b1;
                  for (i = 0; i < NUM_AXES; i++)
                     if (magnitude(gap_of(pose_now, pose_goal, i)) >= step_of(i))
                        settled = 1'b0;
               end
               if (settled) begin
                  pose_now = pose_goal;
                  moving_now = 1'b0;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         ACT_STOP: moving_now = 1'b0;
         ACT_JUMP: begin
            pose_now = pose_goal;
            moving_now = 1'b0;
         end
         ACT_CLEAR: begin
            pose_now = '0;
            pose_goal = '0;
            moving_now = 1'b0;
            ticks_taken = '0;
         end
         default: ;
      endcase
      res.out_x = pose_now[0];
      res.out_y = pose_now[1];
      res.out_z = pose_now[2];
      res.out_roll = pose_now[3];
      res.out_pitch = pose_now[4];
      res.out_yaw = pose_now[5];
      res.moving = moving_now;
      res.step_count = ticks_taken;
      res.keep_going = advance;
      return res;
   endfunction

   function automatic string axis_name(int axis);
      case (axis)
         0: return "out_x";
         1: return "out_y";
         2: return "out_z";
         3: return "out_roll";
         4: return "out_pitch";
         default: return "out_yaw";
      endcase
   endfunction

   task automatic check_result(rsp_type got, rsp_type want);
      pose_vec g;
      pose_vec w;
      int      i;
      g = {got.out_yaw, got.out_pitch, got.out_roll, got.out_z, got.out_y, got.out_x};
      w = {want.out_yaw, want.out_pitch, want.out_roll, want.out_z, want.out_y, want.out_x};
      for (i = 0; i < NUM_AXES; i++) begin
         if (g[i] !== w[i]) begin
            $error("%s expected %0d, got %0d", axis_name(i), coord_type'(w[i]),
                   coord_type'(g[i]));
            fail_count++;
         end
      end
      if (got.moving !== want.moving) begin
         $error("moving expected %0d, got %0d", want.moving, got.moving);
         fail_count++;
      end
      if (got.step_count !== want.step_count) begin
         $error("step_count expected %0d, got %0d", want.step_count, got.step_count);
         fail_count++;
      end
      if (got.keep_going !== want.keep_going) begin
         $error("keep_going expected %0d, got %0d", want.keep_going, got.keep_going);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            pose_results_due.push_back(slew_pose(req_data));
         if (!req_valid || !req_stall) begin
            if (actions_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= actions_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pose_results_due.size() == 0) begin
               $error("result beat arrived with no prediction pending");
               fail_count++;
            end else begin
               check_result(rsp_data, pose_results_due.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $error("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   function automatic pose_vec any_pose();
      pose_vec p;
      int      i;
      for (i = 0; i < NUM_AXES; i++)
         p[i] = COORD_W'($urandom);
      return p;
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base, int lim);
      int span;
      int off;
      int val;
      off = 0;
      case ($urandom_range(7))
         0: off = 0;
         1: off = (lim + int'($urandom_range(2)) - 1) * ($urandom_range(1) ? 1 : -1);
         2: return COORD_W'($urandom);
         default: begin
            span = lim * 6 + 1;
            if (span > 40000)
               span = 40000;
            off = int'($urandom_range(2 * span)) - span;
         end
      endcase
      val = int'(coord_type'(base)) + off;
      if (val > 32767)
         val = 32767;
      if (val < -32768)
         val = -32768;
      return COORD_W'(val);
   endfunction

   task automatic queue_action(logic [2:0] act, pose_vec p);
      req_type r;
      r.action = act;
      r.in_x = p[0];
      r.in_y = p[1];
      r.in_z = p[2];
      r.in_roll = p[3];
      r.in_pitch = p[4];
      r.in_yaw = p[5];
      actions_pending.push_back(r);
   endtask

   task automatic wait_drained();
      while (actions_pending.size() != 0 || req_valid || pose_results_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_POSITION_STEP: pos_step = value[STEP_W-1:0];
         CSR_ANGLE_STEP: ang_step = value[STEP_W-1:0];
         CSR_MAX_STEPS: tick_limit = value[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   initial begin
      pose_vec lowest;
      pose_vec highest;
      pose_vec home;
      pose_vec goal;
      int      phase;
      int      budget;
      int      pick;
      int      n;
      int      i;
      int      k;
      lowest = {NUM_AXES{16'h8000}};
      highest = {NUM_AXES{16'h7FFF}};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_action(ACT_CLEAR, any_pose());
      queue_action(ACT_TICK, any_pose());
      queue_action(ACT_SET_CURRENT, lowest);
      queue_action(ACT_SET_TARGET, highest);
      queue_action(ACT_TICK, any_pose());
      queue_action(ACT_TICK, any_pose());
      queue_action(ACT_STOP, any_pose());
      queue_action(ACT_TICK, any_pose());
      queue_action(ACT_SET_TARGET, highest);
      queue_action(ACT_JUMP, any_pose());
      queue_action(ACT_SET_TARGET, highest);
      queue_action(ACT_CLEAR, any_pose());
      queue_action(ACT_SET_TARGET, {COORD_W'(0), COORD_W'(-81), COORD_W'(81),
                                    COORD_W'(1), COORD_W'(-63), COORD_W'(63)});
      queue_action(ACT_TICK, any_pose());
      queue_action(ACT_SET_TARGET, {COORD_W'(5), COORD_W'(-300), COORD_W'(100),
                                    COORD_W'(0), COORD_W'(-130), COORD_W'(200)});
      repeat (4) queue_action(ACT_TICK, any_pose());
      queue_action(ACT_SPARE_A, any_pose());
      queue_action(ACT_SPARE_B, any_pose());
      queue_action(ACT_CLEAR, any_pose());

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         write_register(CSR_POSITION_STEP, POS_PLAN[phase]);
         write_register(CSR_ANGLE_STEP, ANG_PLAN[phase]);
         write_register(CSR_MAX_STEPS, LIMIT_PLAN[phase]);
         send_idle_pct = SEND_PLAN[phase];
         stall_pct = STALL_PLAN[phase];
         @(negedge clock);
         if (phase == 0) begin
            queue_action(ACT_SET_CURRENT, lowest);
            queue_action(ACT_SET_TARGET, highest);
            repeat (3) queue_action(ACT_TICK, any_pose());
         end
         home = '0;
         budget = 0;
         while (budget < RANDOM_PER_PHASE) begin
            pick = $urandom_range(9);
            if (pick <= 6) begin
               if ($urandom_range(2) == 0) begin
                  home = any_pose();
                  queue_action(ACT_SET_CURRENT, home);
                  budget++;
               end
               for (i = 0; i < NUM_AXES; i++)
                  goal[i] = near_coord(home[i], step_of(i));
               queue_action(ACT_SET_TARGET, goal);
               n = $urandom_range(12, 1);
               for (k = 0; k < n; k++) begin
                  if ($urandom_range(19) == 0)
                     queue_action($urandom_range(1) ? ACT_STOP : ACT_JUMP, any_pose());
                  else
                     queue_action(ACT_TICK, any_pose());
               end
               budget += n + 1;
               home = goal;
            end else if (pick == 7) begin
               queue_action(3'($urandom_range(7)), any_pose());
               budget++;
            end else if (pick == 8) begin
               queue_action(ACT_CLEAR, any_pose());
               home = '0;
               budget++;
            end else begin
               queue_action(ACT_SET_TARGET, any_pose());
               queue_action(ACT_STOP, any_pose());
               queue_action(ACT_TICK, any_pose());
               budget += 3;
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
